/* hdl/sst_pkg.sv */
package sst_pkg;

	localparam int unsigned CAPACITY_DEFAULT = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OP_W = 2;
	localparam int unsigned ENTRY_COUNT_W = 5;

	// operation codes; the unused code behaves as a test
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     was_present;
		logic                     rejected_full;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} rsp_t;

	// broadcast from the table control to every cell
	typedef struct packed {
		logic                      do_insert;
		logic                      do_remove;
		logic signed [VALUE_W-1:0] key;
	} cell_cmd_t;

endpackage

/* hdl/sorted_set_table.sv */
// sorted_set_table keeps up to CAPACITY distinct signed 32-bit keys in ascending order in a row
// of cells, one key per cell. Each request word inserts, removes or tests a key and always
// returns exactly one response word: whether the key was held before, whether an insert of
// a new key was refused because the table was full, and the count afterwards (low 5 bits).
// Requests are taken one per clock while req_stall is low: every cell compares its key
// against the request in the same cycle, and on insert or remove each cell at or above the
// key slot loads from its left or right neighbor. The response sits in an output register,
// which accepts the next request while the current response is being taken. No clearing
// pass is needed after reset; cell contents beyond the count are never reported.
module sorted_set_table #(
	parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sst_pkg::rsp_t rsp
);

	localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_nxt;
	logic               rsp_valid_q;
	sst_pkg::rsp_t      rsp_q;

	logic                 accept;
	logic                 present;
	logic                 full;
	logic                 is_insert;
	logic                 is_remove;
	sst_pkg::cell_cmd_t   cmd;
	logic [CAPACITY-1:0]  lt_vec;
	logic [CAPACITY-1:0]  eq_vec;
	logic signed [sst_pkg::VALUE_W-1:0] cell_value [CAPACITY];

	// output register frees up as soon as its word is taken
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign present   = |eq_vec;
	assign full      = (count_q == COUNT_W'(CAPACITY));
	assign is_insert = (req.operation == sst_pkg::OP_INSERT);
	assign is_remove = (req.operation == sst_pkg::OP_REMOVE);

	// key broadcast to all cells; shifts only on accepted words that change the set
	always_comb begin
		cmd.key       = req.value;
		cmd.do_insert = accept && is_insert && !present && !full;
		cmd.do_remove = accept && is_remove && present;
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.do_insert) begin
			count_nxt = count_q + COUNT_W'(1);
		end else if (cmd.do_remove) begin
			count_nxt = count_q - COUNT_W'(1);
		end
	end

	// row of cells, cell 0 holds the smallest key
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                               left_lt;
		logic signed [sst_pkg::VALUE_W-1:0] left_value;
		logic signed [sst_pkg::VALUE_W-1:0] right_value;

		if (i == 0) begin : g_first
			// nothing to the left: first cell takes the key when it is the insert slot
			assign left_lt    = 1'b1;
			assign left_value = req.value;
		end else begin : g_inner_left
			assign left_lt    = lt_vec[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_inner_right
			assign right_value = cell_value[i+1];
		end

		sst_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (COUNT_W'(i) < count_q),
			.left_lt     (left_lt),
			.left_value  (left_value),
			.right_value (right_value),
			.lt          (lt_vec[i]),
			.eq          (eq_vec[i]),
			.value       (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.was_present   <= present;
			rsp_q.rejected_full <= is_insert && !present && full;
			rsp_q.entry_count   <= sst_pkg::ENTRY_COUNT_W'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hdl/sst_cell.sv */
module sst_cell (
	input  logic                               clk,
	input  sst_pkg::cell_cmd_t                 cmd,
	input  logic                               occupied,
	input  logic                               left_lt,
	input  logic signed [sst_pkg::VALUE_W-1:0] left_value,
	input  logic signed [sst_pkg::VALUE_W-1:0] right_value,
	output logic                               lt,
	output logic                               eq,
	output logic signed [sst_pkg::VALUE_W-1:0] value
);

	logic signed [sst_pkg::VALUE_W-1:0] value_q;
	logic signed [sst_pkg::VALUE_W-1:0] value_nxt;

	assign lt    = occupied && (value_q < cmd.key);
	assign eq    = occupied && (value_q == cmd.key);
	assign value = value_q;

	// entries below the key stay; the rest shift toward or away from the key slot
	always_comb begin
		value_nxt = value_q;
		if (cmd.do_insert && !lt) begin
			value_nxt = left_lt ? cmd.key : left_value;
		end else if (cmd.do_remove && !lt) begin
			value_nxt = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

endmodule
